[rtl/utrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and sizes for the uart transmit/receive ring buffer unit.
// ----------------------------------------------------------------------------
package utrb_pkg;

  localparam int TX_DEPTH = 256;
  localparam int RX_DEPTH = 256;
  localparam int TX_PW    = $clog2(TX_DEPTH);
  localparam int RX_PW    = $clog2(RX_DEPTH);
  localparam int TX_FW    = TX_PW + 1;

  typedef enum logic [1:0] {
    CMD_HOST_WRITE = 2'd0,
    CMD_HOST_READ  = 2'd1,
    CMD_LINE_EVENT = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] host_byte;
    logic       line_rx_valid;
    logic [7:0] line_rx_byte;
    logic       line_tx_empty;
  } item_t;

  typedef struct packed {
    logic        write_accepted;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [31:0] overrun_count;
    logic [7:0]  tx_free_slots;
    logic        tx_irq_enabled;
  } result_t;

endpackage

[rtl/utrb_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_in_if
// Item channel into the ring buffer unit: host and line commands.
// ----------------------------------------------------------------------------
interface utrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] host_byte;
  logic       line_rx_valid;
  logic [7:0] line_rx_byte;
  logic       line_tx_empty;

  modport source (
    output valid, command, host_byte, line_rx_valid, line_rx_byte, line_tx_empty,
    input  ready
  );
  modport sink (
    input  valid, command, host_byte, line_rx_valid, line_rx_byte, line_tx_empty,
    output ready
  );
endinterface

[rtl/utrb_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrb_out_if
// Result channel out of the ring buffer unit: one result per item.
// ----------------------------------------------------------------------------
interface utrb_out_if;
  logic        valid;
  logic        ready;
  logic        write_accepted;
  logic        read_valid;
  logic [7:0]  read_byte;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [31:0] overrun_count;
  logic [7:0]  tx_free_slots;
  logic        tx_irq_enabled;

  modport source (
    output valid, write_accepted, read_valid, read_byte, tx_valid, tx_byte,
           overrun_count, tx_free_slots, tx_irq_enabled,
    input  ready
  );
  modport sink (
    input  valid, write_accepted, read_valid, read_byte, tx_valid, tx_byte,
           overrun_count, tx_free_slots, tx_irq_enabled,
    output ready
  );
endinterface

[rtl/uart_tx_rx_ring_buffers_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_unit
// Transmit and receive byte rings between a host and a serial line.
// ----------------------------------------------------------------------------
// path: an item passes the input register, then the result register
// throughput: one item per cycle while the result side takes results; the
//   ring heads are prefetched from the store reads, so a pop need not
//   wait for a store read
// reset: rst clears pointers, overrun count, service enable and valids;
//   ring stores are not cleared and hold nothing until written
module uart_tx_rx_ring_buffers_unit
  import utrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  utrb_in_if.sink    req,
  utrb_out_if.source rsp
);

  // input and result registers
  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_res;
  result_t res_next;

  logic out_free;
  logic advance;

  // ring state
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [7:0]       tx_head;
  logic [7:0]       rx_head;
  logic [TX_PW-1:0] tx_wr_ptr, tx_wr_ptr_next;
  logic [TX_PW-1:0] tx_rd_ptr, tx_rd_ptr_next;
  logic [RX_PW-1:0] rx_wr_ptr, rx_wr_ptr_next;
  logic [RX_PW-1:0] rx_rd_ptr, rx_rd_ptr_next;
  logic [31:0]      lost_bytes, lost_bytes_next;
  logic             tx_service_enable, tx_service_enable_next;

  logic [TX_PW-1:0] tx_wr_bump, tx_rd_bump;
  logic [RX_PW-1:0] rx_wr_bump, rx_rd_bump;
  logic             tx_push, tx_pop, rx_push, rx_pop, rx_lost;
  logic [TX_FW-1:0] tx_free_raw, tx_free;

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  assign tx_wr_bump = (tx_wr_ptr == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr + 1'b1;
  assign tx_rd_bump = (tx_rd_ptr == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr + 1'b1;
  assign rx_wr_bump = (rx_wr_ptr == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr + 1'b1;
  assign rx_rd_bump = (rx_rd_ptr == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr + 1'b1;

  always_comb begin
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    rx_lost = 1'b0;
    tx_service_enable_next = tx_service_enable;
    if (advance) begin
      unique case (cmd_t'(s1_item.command))
        CMD_HOST_WRITE: begin
          tx_push = (tx_wr_bump != tx_rd_ptr);
          tx_service_enable_next = 1'b1;
        end
        CMD_HOST_READ: begin
          rx_pop = (rx_rd_ptr != rx_wr_ptr);
        end
        CMD_LINE_EVENT: begin
          if (s1_item.line_rx_valid) begin
            rx_push = (rx_wr_bump != rx_rd_ptr);
            rx_lost = (rx_wr_bump == rx_rd_ptr);
          end
          if (s1_item.line_tx_empty && tx_service_enable) begin
            if (tx_rd_ptr != tx_wr_ptr) begin
              tx_pop = 1'b1;
            end else begin
              tx_service_enable_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign tx_wr_ptr_next  = tx_push ? tx_wr_bump : tx_wr_ptr;
  assign tx_rd_ptr_next  = tx_pop  ? tx_rd_bump : tx_rd_ptr;
  assign rx_wr_ptr_next  = rx_push ? rx_wr_bump : rx_wr_ptr;
  assign rx_rd_ptr_next  = rx_pop  ? rx_rd_bump : rx_rd_ptr;
  assign lost_bytes_next = rx_lost ? lost_bytes + 32'd1 : lost_bytes;

  // free slots after this item, read minus write minus one, modulo depth
  assign tx_free_raw = {1'b0, tx_rd_ptr_next} + TX_FW'(TX_DEPTH)
                     - {1'b0, tx_wr_ptr_next} - TX_FW'(1);
  assign tx_free = (tx_free_raw >= TX_FW'(TX_DEPTH)) ? tx_free_raw - TX_FW'(TX_DEPTH)
                                                     : tx_free_raw;

  always_comb begin
    res_next.write_accepted = tx_push;
    res_next.read_valid     = rx_pop;
    res_next.read_byte      = rx_pop ? rx_head : 8'd0;
    res_next.tx_valid       = tx_pop;
    res_next.tx_byte        = tx_pop ? tx_head : 8'd0;
    res_next.overrun_count  = lost_bytes_next;
    res_next.tx_free_slots  = (32'(tx_free) > 32'd255) ? 8'hFF : 8'(tx_free);
    res_next.tx_irq_enabled = tx_service_enable_next;
  end

  // ring stores; the head register tracks the entry at the next read pointer,
  // with write-through when that entry is written in the same cycle
  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_mem[tx_wr_ptr] <= s1_item.host_byte;
    end
    if (tx_push && (tx_wr_ptr == tx_rd_ptr_next)) begin
      tx_head <= s1_item.host_byte;
    end else begin
      tx_head <= tx_mem[tx_rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_push) begin
      rx_mem[rx_wr_ptr] <= s1_item.line_rx_byte;
    end
    if (rx_push && (rx_wr_ptr == rx_rd_ptr_next)) begin
      rx_head <= s1_item.line_rx_byte;
    end else begin
      rx_head <= rx_mem[rx_rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_wr_ptr         <= '0;
      tx_rd_ptr         <= '0;
      rx_wr_ptr         <= '0;
      rx_rd_ptr         <= '0;
      lost_bytes        <= '0;
      tx_service_enable <= 1'b0;
    end else begin
      tx_wr_ptr         <= tx_wr_ptr_next;
      tx_rd_ptr         <= tx_rd_ptr_next;
      rx_wr_ptr         <= rx_wr_ptr_next;
      rx_rd_ptr         <= rx_rd_ptr_next;
      lost_bytes        <= lost_bytes_next;
      tx_service_enable <= tx_service_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.command       <= req.command;
      s1_item.host_byte     <= req.host_byte;
      s1_item.line_rx_valid <= req.line_rx_valid;
      s1_item.line_rx_byte  <= req.line_rx_byte;
      s1_item.line_tx_empty <= req.line_tx_empty;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.write_accepted = out_res.write_accepted;
  assign rsp.read_valid     = out_res.read_valid;
  assign rsp.read_byte      = out_res.read_byte;
  assign rsp.tx_valid       = out_res.tx_valid;
  assign rsp.tx_byte        = out_res.tx_byte;
  assign rsp.overrun_count  = out_res.overrun_count;
  assign rsp.tx_free_slots  = out_res.tx_free_slots;
  assign rsp.tx_irq_enabled = out_res.tx_irq_enabled;

  // a ring is never pushed and popped by the same item
  a_tx_single_op: assert property (@(posedge clk) disable iff (rst)
    !(tx_push && tx_pop))
    else $error("tx ring pushed and popped together");

  // overrun count moves only when a received byte is dropped
  a_lost_only_on_overrun: assert property (@(posedge clk) disable iff (rst)
    !rx_lost |=> $stable(lost_bytes))
    else $error("overrun count changed without a dropped byte");

  // a stalled result is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

[sim/tb_uart_tx_rx_ring_buffers_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_tx_rx_ring_buffers_unit
// Self-checking bench for the uart transmit/receive ring buffer unit.
// Host writes, host reads, line events and the unused code are queued up
// front. A clocked driver feeds them into the item channel with random gaps.
// A clocked monitor keeps its own copy of both rings, the overrun counter and
// the transmit service enable. It works out one expected result per accepted
// item and checks every result field by field. The bench fills both rings
// past full, drains them again, and holds the result side off for long
// stretches so that the unit stalls its input.
// ----------------------------------------------------------------------------
module tb_uart_tx_rx_ring_buffers_unit;
  import utrb_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct {
    item_t       it;
    int unsigned gap;
    bit          drain;
  } pending_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  utrb_in_if  req_if ();
  utrb_out_if rsp_if ();

  uart_tx_rx_ring_buffers_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // own copy of the ring state
  logic [7:0]       tx_mem [TX_DEPTH];
  logic [7:0]       rx_mem [RX_DEPTH];
  logic [TX_PW-1:0] tx_wr;
  logic [TX_PW-1:0] tx_rd;
  logic [RX_PW-1:0] rx_wr;
  logic [RX_PW-1:0] rx_rd;
  logic [31:0]      lost_cnt;
  logic             svc_en;

  pending_cmd_t cmd_queue [$];
  result_t      due_results [$];
  pending_cmd_t next_cmd;
  item_t        seen_item;
  result_t      want;

  int unsigned cmd_total   = 0;
  int unsigned taken_count = 0;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned calm_count  = 0;
  bit          calm        = 1'b0;
  bit          timed_out   = 1'b0;

  bit          live      = 1'b0;
  bit          req_taken = 1'b0;
  bit          rsp_taken = 1'b0;

  int unsigned gap_left   = 0;
  int unsigned cur_gap    = 0;
  bit          cur_drain  = 1'b0;
  bit          hold_drain = 1'b0;

  int unsigned stall_left = 0;
  int unsigned rsp_count  = 0;
  bit          eager      = 1'b0;

  function automatic logic [TX_PW-1:0] tx_next(logic [TX_PW-1:0] p);
    return (int'(p) == TX_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RX_PW-1:0] rx_next(logic [RX_PW-1:0] p);
    return (int'(p) == RX_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic result_t predict_rings(item_t it);
    result_t          r;
    logic [TX_PW-1:0] tx_nx;
    logic [RX_PW-1:0] rx_nx;
    int               free_cnt;
    r = '0;
    case (it.command)
      CMD_HOST_WRITE: begin
        tx_nx = tx_next(tx_wr);
        if (tx_nx != tx_rd) begin
          tx_mem[tx_wr] = it.host_byte;
          tx_wr = tx_nx;
          r.write_accepted = 1'b1;
        end
        svc_en = 1'b1;
      end
      CMD_HOST_READ: begin
        if (rx_rd != rx_wr) begin
          r.read_byte  = rx_mem[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = rx_next(rx_rd);
        end
      end
      CMD_LINE_EVENT: begin
        if (it.line_rx_valid) begin
          rx_nx = rx_next(rx_wr);
          if (rx_nx != rx_rd) begin
            rx_mem[rx_wr] = it.line_rx_byte;
            rx_wr = rx_nx;
          end else begin
            lost_cnt = lost_cnt + 1;
          end
        end
        if (it.line_tx_empty && svc_en) begin
          if (tx_rd != tx_wr) begin
            r.tx_byte  = tx_mem[tx_rd];
            r.tx_valid = 1'b1;
            tx_rd = tx_next(tx_rd);
          end else begin
            svc_en = 1'b0;
          end
        end
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    free_cnt = (int'(tx_rd) + TX_DEPTH - int'(tx_wr) - 1) % TX_DEPTH;
    r.overrun_count  = lost_cnt;
    r.tx_free_slots  = (free_cnt > 255) ? 8'd255 : 8'(free_cnt);
    r.tx_irq_enabled = svc_en;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, exp_v,
               act_v);
      errors++;
    end
  endtask

  task automatic add_item(logic [1:0] cmd, logic [7:0] hb, logic rxv, logic [7:0] rxb,
                          logic txe, bit drain);
    pending_cmd_t e;
    e.it.command       = cmd;
    e.it.host_byte     = hb;
    e.it.line_rx_valid = rxv;
    e.it.line_rx_byte  = rxb;
    e.it.line_tx_empty = txe;
    // stretches without gaps alternate with random gaps
    if (calm_count == 0) begin
      calm       = ~calm;
      calm_count = $urandom_range(20, 60);
    end
    calm_count--;
    e.gap   = calm ? 0 : $urandom_range(0, 8);
    e.drain = drain;
    cmd_queue.push_back(e);
    cmd_total++;
  endtask

  task automatic add_segment(int unsigned n, int unsigned w_wr, int unsigned w_rd,
                             int unsigned w_line, int unsigned p_rxv, int unsigned p_txe);
    int unsigned roll;
    logic [1:0]  cmd;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < w_wr)
        cmd = CMD_HOST_WRITE;
      else if (roll < w_wr + w_rd)
        cmd = CMD_HOST_READ;
      else if (roll < w_wr + w_rd + w_line)
        cmd = CMD_LINE_EVENT;
      else
        cmd = CMD_UNUSED;
      add_item(cmd, 8'($urandom), $urandom_range(0, 99) < p_rxv, 8'($urandom),
               $urandom_range(0, 99) < p_txe, k == n - 1);
    end
  endtask

  // monitor: prediction on input transfers, checking on result transfers
  always @(posedge clk) begin
    if (rst) begin
      live      = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
    end else begin
      live      = 1'b1;
      req_taken = req_if.valid && req_if.ready;
      rsp_taken = rsp_if.valid && rsp_if.ready;
      if (req_taken) begin
        seen_item.command       = req_if.command;
        seen_item.host_byte     = req_if.host_byte;
        seen_item.line_rx_valid = req_if.line_rx_valid;
        seen_item.line_rx_byte  = req_if.line_rx_byte;
        seen_item.line_tx_empty = req_if.line_tx_empty;
        due_results.push_back(predict_rings(seen_item));
        taken_count++;
      end
      if (rsp_taken) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual valid",
                   $time);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("write_accepted", 32'(want.write_accepted),
                      32'(rsp_if.write_accepted));
          check_field("read_valid", 32'(want.read_valid), 32'(rsp_if.read_valid));
          check_field("read_byte", 32'(want.read_byte), 32'(rsp_if.read_byte));
          check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_if.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_if.tx_byte));
          check_field("overrun_count", want.overrun_count, rsp_if.overrun_count);
          check_field("tx_free_slots", 32'(want.tx_free_slots), 32'(rsp_if.tx_free_slots));
          check_field("tx_irq_enabled", 32'(want.tx_irq_enabled),
                      32'(rsp_if.tx_irq_enabled));
        end
      end
    end
  end

  // driver: one item held until its transfer, then its gap
  always @(negedge clk) begin
    if (!live) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_taken) begin
        gap_left   = cur_gap;
        hold_drain = cur_drain;
      end
      if (hold_drain && due_results.size() == 0)
        hold_drain = 1'b0;
      if (!req_if.valid || req_taken) begin
        if (gap_left > 0 || hold_drain) begin
          req_if.valid <= 1'b0;
          if (gap_left > 0)
            gap_left--;
        end else if (cmd_queue.size() != 0) begin
          next_cmd = cmd_queue.pop_front();
          req_if.command       <= next_cmd.it.command;
          req_if.host_byte     <= next_cmd.it.host_byte;
          req_if.line_rx_valid <= next_cmd.it.line_rx_valid;
          req_if.line_rx_byte  <= next_cmd.it.line_rx_byte;
          req_if.line_tx_empty <= next_cmd.it.line_tx_empty;
          req_if.valid         <= 1'b1;
          cur_gap   = next_cmd.gap;
          cur_drain = next_cmd.drain;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with two long hold-offs to fill the unit
  always @(negedge clk) begin
    if (!live) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_taken) begin
        rsp_count++;
        if (rsp_count % 50 == 0)
          eager = 1'($urandom_range(0, 1));
        if (rsp_count == 400 || rsp_count == 1100)
          stall_left = LONG_HOLD;
        else
          stall_left = eager ? 0 : $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no input transfer
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    req_if.valid         = 1'b0;
    req_if.command       = CMD_HOST_WRITE;
    req_if.host_byte     = 8'h00;
    req_if.line_rx_valid = 1'b0;
    req_if.line_rx_byte  = 8'h00;
    req_if.line_tx_empty = 1'b0;
    rsp_if.ready         = 1'b0;
    tx_wr    = '0;
    tx_rd    = '0;
    rx_wr    = '0;
    rx_rd    = '0;
    lost_cnt = '0;
    svc_en   = 1'b0;

    // directed part
    add_item(CMD_HOST_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0); // read of empty ring
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0); // enable still clear
    add_item(CMD_UNUSED,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_HOST_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_HOST_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0); // transmitter busy
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0); // nothing left, enable drops
    add_item(CMD_LINE_EVENT, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
    add_item(CMD_LINE_EVENT, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'hA5, 1'b0, 1'b0); // received byte ignored
    add_item(CMD_HOST_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_HOST_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_HOST_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_item(CMD_HOST_WRITE, 8'h5A, 1'b1, 8'hFF, 1'b1, 1'b0); // line fields ignored
    add_item(CMD_HOST_READ,  8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_item(CMD_LINE_EVENT, 8'hFF, 1'b1, 8'h3C, 1'b1, 1'b0); // store and send together
    add_item(CMD_LINE_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    add_item(CMD_UNUSED,     8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_item(CMD_HOST_WRITE, 8'hC3, 1'b0, 8'h00, 1'b0, 1'b1);

    // random part: mixed, fill tx past full, drain tx, fill rx into overrun, drain rx
    add_segment(100, 30, 30, 35, 50, 50);
    add_segment(350, 85,  5,  8, 50, 10);
    add_segment(330,  3, 10, 85, 20, 95);
    add_segment(350,  3,  5, 90, 95, 30);
    add_segment(300,  5, 80, 13, 20, 50);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!timed_out && !(taken_count == cmd_total && due_results.size() == 0)) begin
      @(negedge clk);
      if (idle_cycles >= IDLE_LIMIT)
        timed_out = 1'b1;
    end
    if (!timed_out)
      repeat (TAIL_CYCLES) @(negedge clk);

    if (!timed_out && errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
